/* rtl/max_clique_backtrack_assert.svh */
// Assertion macros used by the checker file of the maximum clique block.
// Depends on nothing; each macro expects clk_i and rst_ni in scope.
`ifndef MAX_CLIQUE_BACKTRACK_ASSERT_SVH
`define MAX_CLIQUE_BACKTRACK_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define MCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define MCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mcb_pkg.sv */
// Package of the maximum clique block: field widths, command codes,
// controller states, datapath operations and the status struct. No dependencies.
package mcb_pkg;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned NODE_W     = 6;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned MASK_W     = 64;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 72;

  // Command codes carried on the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_EDGE   = 2'd1,
    CMD_SEARCH = 2'd2
  } mcb_cmd_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_RD,
    ST_EDGE_WA,
    ST_EDGE_WB,
    ST_DESCEND,
    ST_FIT,
    ST_EXCL,
    ST_UP
  } mcb_state_e;

  // Operations the controller asks of the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_EDGE_LOAD,
    OP_EDGE_RDA,
    OP_EDGE_WRA,
    OP_EDGE_WRB,
    OP_INIT,
    OP_READ,
    OP_INCL,
    OP_EXCL,
    OP_LEAF,
    OP_POP,
    OP_UP,
    OP_FINISH
  } mcb_op_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic edge_ok;
    logic leaf;
    logic fits;
    logic bound_ok;
    logic at_root;
    logic taken_p;
    logic out_busy;
  } mcb_stat_t;

endpackage

/* rtl/max_clique_backtrack.sv */
// Top level of the maximum clique block: stream ports, controller and datapath.
// Depends on mcb_pkg, mcb_ctrl, mcb_dp (and mcb_ram below it).
//
//   Channel  | Direction | Handshake              | Carries
//   s_axis   | in        | tvalid/tready          | tuser cmd, tdata node_a, node_b
//   m_axis   | out       | tvalid/tready          | tdata clique_size, clique_members
//   cfg      | in        | cfg_we_i               | node_count
//
// A clear is done when it is accepted; an edge is accepted and then runs EDGE_RD,
// EDGE_WA and EDGE_WB on the single write port, one read-modify-write per endpoint row.
// A search is accepted, then each inner tree node takes DESCEND (adjacency row read)
// and FIT (include test), a leaf takes DESCEND, an exclude test EXCL and a backtrack
// step UP; the walk follows the pruned search tree.
// Reset empties the graph at once through per-row valid bits; no sweep runs.
// A held result on m_axis lets the next search run; that search waits at its
// last step until the result register is free, and later requests wait behind it.
module max_clique_backtrack
  import mcb_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [5:0] node_a, [11:6] node_b, rest zero
  input  logic [CMD_W-1:0]      s_axis_tuser,  // [1:0] cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [6:0] clique_size, [70:7] clique_members
  input  logic                  cfg_we_i,
  input  logic [CNT_W-1:0]      cfg_wdata_i
);

  mcb_op_e          op;
  mcb_stat_t        stat;
  logic [CNT_W-1:0]  out_size;
  logic [MASK_W-1:0] out_members;

  mcb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .op_o       (op)
  );

  mcb_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .in_a_i        (s_axis_tdata[NODE_W-1:0]),
    .in_b_i        (s_axis_tdata[2*NODE_W-1:NODE_W]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_size_o    (out_size),
    .out_members_o (out_members),
    .stat_o        (stat)
  );

  assign m_axis_tdata = {1'b0, out_members, out_size};

endmodule

/* rtl/mcb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mcb_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mcb_ctrl.sv */
// Controller of the maximum clique block: command decode, edge update
// sequence and the backtracking walk. Depends on mcb_pkg.
module mcb_ctrl
  import mcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  input  mcb_stat_t        stat_i,
  output logic             in_ready_o,
  output mcb_op_e          op_o
);

  mcb_state_e state_q, state_d;
  logic       accept;

  // New requests are taken only while idle.
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd_i)
            CMD_EDGE: begin
              if (stat_i.edge_ok) state_d = ST_EDGE_RD;
            end
            CMD_SEARCH: state_d = ST_DESCEND;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_EDGE_RD: state_d = ST_EDGE_WA;
      ST_EDGE_WA: state_d = ST_EDGE_WB;
      ST_EDGE_WB: state_d = ST_IDLE;
      ST_DESCEND: begin
        state_d = stat_i.leaf ? ST_UP : ST_FIT;
      end
      ST_FIT: begin
        state_d = stat_i.fits ? ST_DESCEND : ST_EXCL;
      end
      ST_EXCL: begin
        state_d = stat_i.bound_ok ? ST_DESCEND : ST_UP;
      end
      ST_UP: begin
        // At the root the result waits until the output register is free.
        if (stat_i.at_root) begin
          state_d = stat_i.out_busy ? ST_UP : ST_IDLE;
        end else if (stat_i.taken_p) begin
          state_d = ST_EXCL;
        end else begin
          state_d = ST_UP;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath operation for the current state.
  always_comb begin
    op_o = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd_i)
            CMD_CLEAR:  op_o = OP_CLEAR;
            CMD_EDGE:   op_o = stat_i.edge_ok ? OP_EDGE_LOAD : OP_NONE;
            CMD_SEARCH: op_o = OP_INIT;
            default:    op_o = OP_NONE;
          endcase
        end
      end
      ST_EDGE_RD: op_o = OP_EDGE_RDA;
      ST_EDGE_WA: op_o = OP_EDGE_WRA;
      ST_EDGE_WB: op_o = OP_EDGE_WRB;
      ST_DESCEND: op_o = stat_i.leaf ? OP_LEAF : OP_READ;
      ST_FIT:     op_o = stat_i.fits ? OP_INCL : OP_NONE;
      ST_EXCL:    op_o = stat_i.bound_ok ? OP_EXCL : OP_NONE;
      ST_UP: begin
        if (stat_i.at_root) begin
          op_o = stat_i.out_busy ? OP_NONE : OP_FINISH;
        end else if (stat_i.taken_p) begin
          op_o = OP_POP;
        end else begin
          op_o = OP_UP;
        end
      end
      default: op_o = OP_NONE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/mcb_dp.sv */
// Datapath of the maximum clique block: adjacency RAM with row valid bits,
// search registers, bound check and the result register. Depends on mcb_pkg, mcb_ram.
module mcb_dp
  import mcb_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcb_op_e           op_i,
  input  logic [NODE_W-1:0] in_a_i,
  input  logic [NODE_W-1:0] in_b_i,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [CNT_W-1:0]  out_size_o,
  output logic [MASK_W-1:0] out_members_o,
  output mcb_stat_t         stat_o
);

  localparam int unsigned NW = MAX_NODES;
  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned LW = $clog2(MAX_NODES + 1);

  // Configuration and search state.
  logic [CNT_W-1:0] node_count_q;
  logic [LW-1:0]    span_q, span_d;
  logic [LW-1:0]    t_q, t_d;
  logic [LW-1:0]    cnt_q, cnt_d;
  logic [LW-1:0]    best_cnt_q, best_cnt_d;
  logic [NW-1:0]    cur_q, cur_d;
  logic [NW-1:0]    taken_q, taken_d;
  logic [NW-1:0]    best_q, best_d;
  logic [NW-1:0]    adj_vld_q, adj_vld_d;
  logic             rd_vld_q;
  logic [AW-1:0]    a_q, b_q;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] out_size_q;
  logic [MASK_W-1:0] out_members_q;

  // Derived values.
  logic [LW-1:0] p;
  logic [NW-1:0] bit_t, bit_p, bit_a, bit_b, row;
  logic [LW:0]   bound_lhs, bound_rhs;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [NW-1:0] ram_wdata, ram_rdata;

  assign p     = t_q - LW'(1);
  assign bit_t = NW'(1) << t_q[AW-1:0];
  assign bit_p = NW'(1) << p[AW-1:0];
  assign bit_a = NW'(1) << a_q;
  assign bit_b = NW'(1) << b_q;
  // A row never written since the last clear reads as empty.
  assign row   = rd_vld_q ? ram_rdata : '0;

  // Exclude branch is worth taking when count + (span - 1 - t) > best.
  assign bound_lhs = {1'b0, cnt_q} + {1'b0, span_q};
  assign bound_rhs = {1'b0, best_cnt_q} + {1'b0, t_q} + (LW+1)'(1);

  // Status toward the controller.
  always_comb begin
    stat_o.edge_ok  = (in_a_i != in_b_i) &&
                      ({1'b0, in_a_i} < (NODE_W+1)'(MAX_NODES)) &&
                      ({1'b0, in_b_i} < (NODE_W+1)'(MAX_NODES));
    stat_o.leaf     = (t_q >= span_q);
    stat_o.fits     = ((cur_q & ~row) == '0);
    stat_o.bound_ok = (bound_lhs > bound_rhs);
    stat_o.at_root  = (t_q == '0);
    stat_o.taken_p  = taken_q[p[AW-1:0]];
    stat_o.out_busy = out_valid_q;
  end

  // Adjacency RAM ports: a read-modify-write on each endpoint row.
  always_comb begin
    ram_we    = (op_i == OP_EDGE_WRA) || (op_i == OP_EDGE_WRB);
    ram_waddr = (op_i == OP_EDGE_WRA) ? a_q : b_q;
    ram_wdata = row | ((op_i == OP_EDGE_WRA) ? bit_b : bit_a);
    if (op_i == OP_EDGE_RDA) begin
      ram_raddr = a_q;
    end else if (op_i == OP_EDGE_WRA) begin
      ram_raddr = b_q;
    end else begin
      ram_raddr = t_q[AW-1:0];
    end
  end

  mcb_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_NODES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next values of the search and store state.
  always_comb begin
    span_d      = span_q;
    t_d         = t_q;
    cnt_d       = cnt_q;
    best_cnt_d  = best_cnt_q;
    cur_d       = cur_q;
    taken_d     = taken_q;
    best_d      = best_q;
    adj_vld_d   = adj_vld_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (op_i)
      OP_CLEAR: adj_vld_d = '0;
      OP_EDGE_WRA: adj_vld_d = adj_vld_q | bit_a;
      OP_EDGE_WRB: adj_vld_d = adj_vld_q | bit_b;
      OP_INIT: begin
        span_d     = (node_count_q > CNT_W'(MAX_NODES)) ? LW'(MAX_NODES)
                                                        : node_count_q[LW-1:0];
        t_d        = '0;
        cnt_d      = '0;
        best_cnt_d = '0;
        cur_d      = '0;
        taken_d    = '0;
        best_d     = '0;
      end
      OP_INCL: begin
        cur_d   = cur_q | bit_t;
        taken_d = taken_q | bit_t;
        cnt_d   = cnt_q + LW'(1);
        t_d     = t_q + LW'(1);
      end
      OP_EXCL: t_d = t_q + LW'(1);
      OP_LEAF: begin
        // Only a strictly larger clique replaces the best one.
        if (cnt_q > best_cnt_q) begin
          best_cnt_d = cnt_q;
          best_d     = cur_q;
        end
      end
      OP_POP: begin
        t_d     = p;
        cur_d   = cur_q & ~bit_p;
        taken_d = taken_q & ~bit_p;
        cnt_d   = cnt_q - LW'(1);
      end
      OP_UP: t_d = p;
      OP_FINISH: out_valid_d = 1'b1;
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(1);
      span_q       <= '0;
      t_q          <= '0;
      cnt_q        <= '0;
      best_cnt_q   <= '0;
      cur_q        <= '0;
      taken_q      <= '0;
      best_q       <= '0;
      adj_vld_q    <= '0;
      rd_vld_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      span_q      <= span_d;
      t_q         <= t_d;
      cnt_q       <= cnt_d;
      best_cnt_q  <= best_cnt_d;
      cur_q       <= cur_d;
      taken_q     <= taken_d;
      best_q      <= best_d;
      adj_vld_q   <= adj_vld_d;
      rd_vld_q    <= adj_vld_q[ram_raddr];
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: edge endpoints and the result.
  always_ff @(posedge clk_i) begin
    if (op_i == OP_EDGE_LOAD) begin
      a_q <= in_a_i[AW-1:0];
      b_q <= in_b_i[AW-1:0];
    end
    if (op_i == OP_FINISH) begin
      out_size_q    <= CNT_W'(best_cnt_q);
      out_members_q <= MASK_W'(best_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_size_o    = out_size_q;
  assign out_members_o = out_members_q;

endmodule

/* rtl/mcb_checker.sv */
// Port-level checker for the maximum clique block, bound to the top level.
// Depends on mcb_pkg and max_clique_backtrack_assert.svh.
`include "max_clique_backtrack_assert.svh"

module mcb_checker
  import mcb_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [CMD_W-1:0]      s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic search_req;
  assign search_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SEARCH);

  // A stalled result stays valid and unchanged.
  `MCB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // A waiting request stays valid and unchanged until it is taken.
  `MCB_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready,
    s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser),
    "request changed while waiting")

  // The block is busy right after taking a search request.
  `MCB_ASSERT_NEXT(a_search_busy, search_req, !s_axis_tready,
    "block ready in the cycle after a search request")

  // The reported size matches the member mask and the node limit.
  `MCB_ASSERT_NOW(a_size_match, m_axis_tvalid,
    ($countones(m_axis_tdata[70:7]) == int'(m_axis_tdata[6:0])) &&
    (m_axis_tdata[6:0] <= CNT_W'(MAX_NODES)),
    "clique size does not match member mask")

endmodule

bind max_clique_backtrack mcb_checker #(.MAX_NODES(MAX_NODES)) u_mcb_checker (.*);

/* tb/sv/testbench.sv */
// Self-checking testbench for max_clique_backtrack: streams graph-edit and search requests
// and checks every clique result against a branch-and-bound predictor held in the bench.
// Depends on mcb_pkg and the max_clique_backtrack RTL.
module testbench;
  import mcb_pkg::*;

  localparam int unsigned GRAPH_NODES   = 64;
  localparam int unsigned RANDOM_ITEMS  = 800;
  localparam int unsigned MIN_SEARCHES  = 40;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One request on the input stream and one clique result on the output stream.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } graph_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  clique_size;
    logic [MASK_W-1:0] clique_members;
  } clique_result_t;

  // Where the search stands at one level of the tree.
  typedef enum int {
    TRY_INCLUDE,
    TRY_EXCLUDE,
    RETURN_UP
  } branch_step_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CNT_W-1:0]      cfg_wdata_i   = '0;

  // Bench copy of the graph and of the node_count register.
  logic [MASK_W-1:0] graph_adj [GRAPH_NODES];
  logic [CNT_W-1:0]  model_node_count = 7'd1;

  graph_req_t     graph_requests [$];
  clique_result_t clique_expected [$];
  graph_req_t     req_now;

  int unsigned send_wait      = 0;
  int unsigned take_wait      = 0;
  bit          send_eager     = 1'b0;
  bit          take_eager     = 1'b0;
  int unsigned real_items     = 0;
  int unsigned searches_sent  = 0;
  int unsigned reqs_accepted  = 0;
  int unsigned results_seen   = 0;
  int unsigned count_settings = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;

  max_clique_backtrack #(
    .MAX_NODES(GRAPH_NODES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Explicit-stack branch and bound: include before exclude, nodes in increasing order,
  // and the best is only replaced by a strictly larger clique.
  function automatic clique_result_t search_max_clique(input int span);
    int           level_node [0:GRAPH_NODES];
    branch_step_e level_step [0:GRAPH_NODES];
    int           top;
    int           t;
    int           chosen;
    int           best_count;
    logic [MASK_W-1:0] chosen_set;
    logic [MASK_W-1:0] best_set;
    clique_result_t    res;
    top = 0;
    level_node[0] = 0;
    level_step[0] = TRY_INCLUDE;
    chosen = 0;
    best_count = 0;
    chosen_set = '0;
    best_set = '0;
    while (top >= 0) begin
      t = level_node[top];
      if (level_step[top] == TRY_INCLUDE && t >= span) begin
        if (chosen > best_count) begin
          best_count = chosen;
          best_set = chosen_set;
        end
        top--;
      end else if (level_step[top] == TRY_INCLUDE) begin
        level_step[top] = TRY_EXCLUDE;
        if ((chosen_set & ~graph_adj[t]) == '0) begin
          chosen_set[t] = 1'b1;
          chosen++;
          top++;
          level_node[top] = t + 1;
          level_step[top] = TRY_INCLUDE;
        end
      end else if (level_step[top] == TRY_EXCLUDE) begin
        // Undo the include, if there was one, then descend without node t if the bound allows.
        if (chosen_set[t]) begin
          chosen_set[t] = 1'b0;
          chosen--;
        end
        level_step[top] = RETURN_UP;
        if (chosen + (span - 1 - t) > best_count) begin
          top++;
          level_node[top] = t + 1;
          level_step[top] = TRY_INCLUDE;
        end
      end else begin
        top--;
      end
    end
    res.clique_size = CNT_W'(best_count);
    res.clique_members = best_set;
    return res;
  endfunction

  // Update the bench graph for an accepted request and queue any result it causes.
  function automatic void apply_request(input graph_req_t r);
    int span;
    span = (model_node_count > GRAPH_NODES) ? GRAPH_NODES : int'(model_node_count);
    case (r.cmd)
      CMD_CLEAR: begin
        foreach (graph_adj[i]) graph_adj[i] = '0;
      end
      CMD_EDGE: begin
        if (r.node_a != r.node_b) begin
          graph_adj[r.node_a][r.node_b] = 1'b1;
          graph_adj[r.node_b][r.node_a] = 1'b1;
        end
      end
      CMD_SEARCH: begin
        clique_expected.push_back(search_max_clique(span));
      end
      default: begin
      end
    endcase
  endfunction

  // Queue one request; every request counts toward the stimulus total.
  function automatic void push_request(input logic [CMD_W-1:0] cmd,
                                       input logic [NODE_W-1:0] a,
                                       input logic [NODE_W-1:0] b);
    graph_req_t r;
    r.cmd = cmd;
    r.node_a = a;
    r.node_b = b;
    graph_requests.push_back(r);
    if (cmd == CMD_SEARCH) searches_sent++;
    real_items++;
  endfunction

  // Random endpoint among the nodes taking part in the search, or any node when fewer than two take part.
  function automatic logic [NODE_W-1:0] pick_node(input int span);
    if (span < 2) return NODE_W'($urandom);
    return NODE_W'($urandom_range(0, span - 1));
  endfunction

  // Wait until every request is in and every result is out, then let the block settle.
  task automatic wait_until_idle();
    @(negedge clk_i);
    while (graph_requests.size() != 0 || s_axis_tvalid || clique_expected.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_node_count(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    model_node_count = value;
    count_settings++;
  endtask

  // Request driver: presents queued requests with a random gap after each one.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(req_now);
        reqs_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (graph_requests.size() != 0) begin
          req_now = graph_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= req_now.cmd;
          s_axis_tdata  <= IN_DATA_W'({req_now.node_b, req_now.node_a});
          send_wait = send_eager ? 0 : $urandom_range(0, 17);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each result and stalls a random time after it.
  always @(posedge clk_i) begin
    clique_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (clique_expected.size() == 0) begin
          $error("clique result with no search waiting: size %0d members %h",
                 m_axis_tdata[CNT_W-1:0], m_axis_tdata[CNT_W+MASK_W-1:CNT_W]);
          error_count++;
        end else begin
          want = clique_expected.pop_front();
          if (m_axis_tdata[CNT_W-1:0] !== want.clique_size) begin
            $error("clique_size: expected %0d, got %0d",
                   want.clique_size, m_axis_tdata[CNT_W-1:0]);
            error_count++;
          end
          if (m_axis_tdata[CNT_W+MASK_W-1:CNT_W] !== want.clique_members) begin
            $error("clique_members: expected %h, got %h",
                   want.clique_members, m_axis_tdata[CNT_W+MASK_W-1:CNT_W]);
            error_count++;
          end
        end
        take_wait = take_eager ? 0 : $urandom_range(0, 17);
      end else if (take_wait > 0) begin
        take_wait--;
      end
      m_axis_tready <= (take_wait == 0);
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Stimulus: directed cases first, then random phases with one node_count each.
  initial begin
    int          nc;
    int          span;
    int          rounds;
    int          n_edges;
    int          kind;
    int          k;
    int unsigned random_start;
    int unsigned search_start;
    logic [NODE_W-1:0] planted [6];

    foreach (graph_adj[i]) graph_adj[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Search with node_count at its reset value of one.
    push_request(CMD_SEARCH, NODE_W'($urandom), NODE_W'($urandom));
    wait_until_idle();

    // No nodes at all gives an empty clique.
    write_node_count(7'd0);
    push_request(CMD_SEARCH, NODE_W'($urandom), NODE_W'($urandom));
    wait_until_idle();

    // Six nodes: a triangle, a self-loop, an edge outside the span, an unused command,
    // then a second triangle of equal size that must not replace the first.
    write_node_count(7'd6);
    push_request(CMD_CLEAR, 6'd63, 6'd63);
    push_request(CMD_EDGE, 6'd0, 6'd1);
    push_request(CMD_EDGE, 6'd1, 6'd2);
    push_request(CMD_EDGE, 6'd2, 6'd0);
    push_request(CMD_EDGE, 6'd3, 6'd3);
    push_request(CMD_EDGE, 6'd4, 6'd5);
    push_request(CMD_EDGE, 6'd63, 6'd0);
    push_request(CMD_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
    push_request(CMD_SEARCH, 6'd0, 6'd0);
    push_request(CMD_EDGE, 6'd3, 6'd4);
    push_request(CMD_EDGE, 6'd5, 6'd3);
    push_request(CMD_SEARCH, 6'd63, 6'd63);
    push_request(CMD_CLEAR, 6'd0, 6'd0);
    push_request(CMD_SEARCH, NODE_W'($urandom), NODE_W'($urandom));
    wait_until_idle();

    // Count above the node limit saturates; the clique sits on the top nodes.
    write_node_count(7'd127);
    push_request(CMD_EDGE, 6'd63, 6'd62);
    push_request(CMD_EDGE, 6'd61, 6'd63);
    push_request(CMD_EDGE, 6'd62, 6'd61);
    push_request(CMD_SEARCH, NODE_W'($urandom), NODE_W'($urandom));
    wait_until_idle();

    // Random phases: mostly small graphs built from scratch, a few at full size.
    random_start = real_items;
    search_start = searches_sent;
    while (real_items - random_start < RANDOM_ITEMS ||
           searches_sent - search_start < MIN_SEARCHES) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) nc = 0;
      else if (kind == 1) nc = 1;
      else if (kind == 2) nc = 64;
      else if (kind == 3) nc = $urandom_range(65, 127);
      else nc = $urandom_range(2, 16);
      write_node_count(CNT_W'(nc));
      span = (nc > GRAPH_NODES) ? GRAPH_NODES : nc;
      send_eager = ($urandom_range(0, 3) == 0);
      take_eager = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0)
        push_request(CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
      rounds = $urandom_range(1, 3);
      repeat (rounds) begin
        // Large graphs get a small planted clique among sparse random edges.
        if (span > 16) begin
          k = $urandom_range(3, 6);
          for (int i = 0; i < k; i++) planted[i] = pick_node(span);
          for (int i = 0; i < k; i++)
            for (int j = i + 1; j < k; j++)
              push_request(CMD_EDGE, planted[i], planted[j]);
          n_edges = $urandom_range(0, 30);
        end else begin
          n_edges = $urandom_range(0, span + 4);
        end
        repeat (n_edges) begin
          kind = $urandom_range(0, 19);
          if (kind == 0) begin
            k = $urandom_range(0, 63);
            push_request(CMD_EDGE, NODE_W'(k), NODE_W'(k));
          end else if (kind == 1) begin
            push_request(CMD_UNUSED, NODE_W'($urandom), NODE_W'($urandom));
          end else if (kind <= 3) begin
            push_request(CMD_EDGE, NODE_W'($urandom), NODE_W'($urandom));
          end else if (kind == 4 && $urandom_range(0, 3) == 0) begin
            push_request(CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom));
          end else begin
            push_request(CMD_EDGE, pick_node(span), pick_node(span));
          end
        end
        push_request(CMD_SEARCH, NODE_W'($urandom), NODE_W'($urandom));
      end
      wait_until_idle();
    end

    $display("testbench summary: %0d requests accepted, %0d clique results checked,",
             reqs_accepted, results_seen);
    $display("  %0d node_count settings between 0 and 127, %0d mismatches",
             count_settings, error_count);
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
